FILE: hdl/adsr_pkg.sv
`timescale 1ns / 1ps
// Shared widths, reset values, register codes and item types of the ADSR envelope shaper.
// No dependencies; compile before every other file of the block.
package adsr_pkg;

    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int LEVEL_W    = 16;
    localparam int SAMPLE_W   = 16;

    localparam int MUL_A_W    = 24;
    localparam int MUL_B_W    = 16;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int QUOT_W     = 16;
    localparam int STEP_W     = 4;

    localparam int UNITY_W    = 30;
    localparam int SCALE_SH   = 15;
    localparam int SCALE_W    = UNITY_W + SCALE_SH;
    localparam logic [UNITY_W-1:0] UNITY_Q29 = 30'h2000_0000;
    localparam logic [SAMPLE_W-1:0] OUT_SCALE = 16'd32766;

    localparam logic [CFG_W-1:0]   NOTE_LENGTH_RST = 24'd48000;
    localparam logic [CFG_W-1:0]   ATTACK_RST      = 24'd480;
    localparam logic [CFG_W-1:0]   DECAY_RST       = 24'd4800;
    localparam logic [CFG_W-1:0]   RELEASE_RST     = 24'd4800;
    localparam logic [LEVEL_W-1:0] PEAK_RST        = 16'd16384;
    localparam logic [LEVEL_W-1:0] SUSTAIN_RST     = 16'd8192;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOTE_LENGTH = 3'd0,
        CFG_ATTACK      = 3'd1,
        CFG_DECAY       = 3'd2,
        CFG_RELEASE     = 3'd3,
        CFG_PEAK        = 3'd4,
        CFG_SUSTAIN     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] wave_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       note_last;
    } t_out_item;

endpackage

FILE: hdl/adsr_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one request of payload type T.
// Used with the item types of adsr_pkg.
interface adsr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/adsr_serial_mul.sv
`timescale 1ns / 1ps
// Shift-add multiplier, one multiplier bit per cycle, unsigned 24 x 16 bits.
// Depends on adsr_pkg.
module adsr_serial_mul
    import adsr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_A_W-1:0] i_mcand,
    input  logic [MUL_B_W-1:0] i_mplier,
    output logic               o_done,
    output logic [PROD_W-1:0]  o_prod
);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MUL_B_W - 1);

    logic [MUL_A_W-1:0] r_mcand;
    logic [PROD_W-1:0]  r_acc;
    logic [PROD_W-1:0]  n_acc;
    logic [STEP_W-1:0]  r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [MUL_A_W:0]   sum;

    always_comb begin
        sum   = {1'b0, r_acc[PROD_W-1:MUL_B_W]} + (r_acc[0] ? {1'b0, r_mcand} : '0);
        n_acc = {sum, r_acc[MUL_B_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == STEP_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_acc   <= PROD_W'(i_mplier);
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

FILE: hdl/adsr_serial_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle; the quotient is known to fit 16 bits.
// Depends on adsr_pkg.
module adsr_serial_div
    import adsr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [PROD_W-1:0]  i_num,
    input  logic [CFG_W-1:0]   i_den,
    output logic               o_done,
    output logic [QUOT_W-1:0]  o_quot
);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUOT_W - 1);

    logic [CFG_W-1:0]  r_den;
    logic [CFG_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_low;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [CFG_W:0]    part;
    logic [CFG_W:0]    diff;
    logic              fits;

    always_comb begin
        part = {r_rem, r_low[QUOT_W-1]};
        diff = part - {1'b0, r_den};
        fits = part >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == STEP_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= i_num[PROD_W-1:QUOT_W];
            r_low <= i_num[QUOT_W-1:0];
        end else if (r_busy) begin
            r_rem <= fits ? diff[CFG_W-1:0] : part[CFG_W-1:0];
            r_low <= {r_low[QUOT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_low;
endmodule

FILE: hdl/adsr_envelope_shaper.sv
`timescale 1ns / 1ps
// ADSR envelope shaper: region select, serial ramp gain, serial gain multiply, scaling.
// Requests are taken one at a time, only in the idle state, after the previous result has
// been registered for output. Ramps (attack, decay, release) use the shared 16-step shift-add
// multiplier twice, with the 16-step divider between; sustain and silence use it once.
// Reset (synchronous, active low) restores register defaults, index 0.
module adsr_envelope_shaper
    import adsr_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    adsr_stream_if.sink          i_in,
    adsr_stream_if.source        o_out
);
    localparam int W = ((COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W) + 1;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_REGION = 8'b0000_0010,
        ST_LOAD   = 8'b0000_0100,
        ST_MUL    = 8'b0000_1000,
        ST_DIV    = 8'b0001_0000,
        ST_GAIN   = 8'b0010_0000,
        ST_SCALE  = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0]      r_note;
    logic [CFG_W-1:0]      r_att;
    logic [CFG_W-1:0]      r_dec;
    logic [CFG_W-1:0]      r_rel;
    logic [LEVEL_W-1:0]    r_peak;
    logic [LEVEL_W-1:0]    r_sus;

    logic [COUNT_BITS-1:0] r_index;
    logic [COUNT_BITS-1:0] r_cur;
    logic                  r_last;
    logic [SAMPLE_W-1:0]   r_wave;
    logic [SAMPLE_W-1:0]   r_wmag;
    logic                  r_lt_a;
    logic                  r_lt_ad;
    logic                  r_lt_note;
    logic [CFG_W-1:0]      r_gap;
    logic [CFG_W-1:0]      r_dec_t;
    logic [LEVEL_W-1:0]    r_pms;
    logic                  r_p_lt_s;
    logic [LEVEL_W-1:0]    r_base;
    logic                  r_sub;
    logic [CFG_W-1:0]      r_den;
    logic [LEVEL_W-1:0]    r_gain;
    logic                  r_second;
    logic [SAMPLE_W-1:0]   r_mag;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  in_acc;
    logic                  emit_go;
    logic [W-1:0]          inc_w;
    logic                  next_last;
    logic [W-1:0]          cur_w;
    logic [W-1:0]          gap_w;
    logic [W-1:0]          dec_w;
    logic                  ld_ramp;
    logic [CFG_W-1:0]      ld_t;
    logic [LEVEL_W-1:0]    ld_m;
    logic [CFG_W-1:0]      ld_den;
    logic [LEVEL_W-1:0]    ld_base;
    logic                  ld_sub;
    logic [LEVEL_W-1:0]    ld_gain;
    logic [CFG_W-1:0]      rel_t;

    logic                  mul_start;
    logic [MUL_A_W-1:0]    mul_mcand;
    logic [MUL_B_W-1:0]    mul_mplier;
    logic                  mul_done;
    logic [PROD_W-1:0]     mul_prod;
    logic                  div_start;
    logic                  div_done;
    logic [QUOT_W-1:0]     div_quot;
    logic [LEVEL_W-1:0]    ramp_gain;
    logic [UNITY_W-1:0]    clamped;
    logic [SCALE_W-1:0]    scaled;

    assign in_acc  = i_in.valid && i_in.ready;
    assign emit_go = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note <= NOTE_LENGTH_RST;
            r_att  <= ATTACK_RST;
            r_dec  <= DECAY_RST;
            r_rel  <= RELEASE_RST;
            r_peak <= PEAK_RST;
            r_sus  <= SUSTAIN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NOTE_LENGTH: r_note <= i_cfg_data;
                CFG_ATTACK:      r_att  <= i_cfg_data;
                CFG_DECAY:       r_dec  <= i_cfg_data;
                CFG_RELEASE:     r_rel  <= i_cfg_data;
                CFG_PEAK:        r_peak <= i_cfg_data[LEVEL_W-1:0];
                CFG_SUSTAIN:     r_sus  <= i_cfg_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        inc_w     = W'(r_index) + W'(1);
        next_last = inc_w >= W'(r_note);
        cur_w     = W'(r_cur);
        gap_w     = W'(r_note) - cur_w;
        dec_w     = cur_w - W'(r_att);
        rel_t     = r_rel - r_gap;
    end

    // region decode of the current index
    always_comb begin
        ld_ramp = 1'b0;
        ld_t    = '0;
        ld_m    = '0;
        ld_den  = '0;
        ld_base = '0;
        ld_sub  = 1'b0;
        ld_gain = '0;
        if (r_lt_a) begin
            ld_ramp = 1'b1;
            ld_t    = cur_w[CFG_W-1:0];
            ld_m    = r_peak;
            ld_den  = r_att;
        end else if (r_lt_ad) begin
            ld_ramp = 1'b1;
            ld_t    = r_dec_t;
            ld_m    = r_pms;
            ld_den  = r_dec;
            ld_base = r_peak;
            ld_sub  = !r_p_lt_s;
        end else if (r_lt_note && (r_rel < r_gap)) begin
            ld_gain = r_sus;
        end else if ((r_rel != '0) && r_lt_note) begin
            ld_ramp = 1'b1;
            ld_t    = rel_t;
            ld_m    = r_sus;
            ld_den  = r_rel;
            ld_base = r_sus;
            ld_sub  = 1'b1;
        end
    end

    assign mul_start  = ((r_state == ST_LOAD) && ld_ramp) || (r_state == ST_GAIN);
    assign mul_mcand  = (r_state == ST_GAIN) ? MUL_A_W'(r_gain) : ld_t;
    assign mul_mplier = (r_state == ST_GAIN) ? r_wmag : ld_m;
    assign div_start  = (r_state == ST_MUL) && mul_done && !r_second;
    assign ramp_gain  = r_sub ? (r_base - div_quot) : (r_base + div_quot);

    always_comb begin
        clamped = (mul_prod[PROD_W-1:UNITY_W] != '0 || mul_prod[UNITY_W-1:0] > UNITY_Q29)
                  ? UNITY_Q29 : mul_prod[UNITY_W-1:0];
        scaled  = {clamped, SCALE_SH'(0)} - SCALE_W'({clamped, 1'b0});
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_acc) n_state = ST_REGION;
            ST_REGION: n_state = ST_LOAD;
            ST_LOAD:   n_state = ld_ramp ? ST_MUL : ST_GAIN;
            ST_MUL: begin
                if (mul_done) begin
                    n_state = r_second ? ST_SCALE : ST_DIV;
                end
            end
            ST_DIV:    if (div_done) n_state = ST_GAIN;
            ST_GAIN:   n_state = ST_MUL;
            ST_SCALE:  n_state = ST_EMIT;
            ST_EMIT:   if (emit_go) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_index     <= '0;
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_index <= next_last ? '0 : inc_w[COUNT_BITS-1:0];
            end
            if (r_state == ST_LOAD) begin
                r_second <= 1'b0;
            end else if (r_state == ST_GAIN) begin
                r_second <= 1'b1;
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_wave <= i_in.data.wave_sample;
            r_cur  <= r_index;
            r_last <= next_last;
        end
        if (r_state == ST_REGION) begin
            r_wmag    <= r_wave[SAMPLE_W-1] ? (~r_wave + 1'b1) : r_wave;
            r_lt_a    <= cur_w < W'(r_att);
            r_lt_ad   <= cur_w < (W'(r_att) + W'(r_dec));
            r_lt_note <= cur_w < W'(r_note);
            r_gap     <= gap_w[CFG_W-1:0];
            r_dec_t   <= dec_w[CFG_W-1:0];
            r_p_lt_s  <= r_peak < r_sus;
            r_pms     <= (r_peak < r_sus) ? (r_sus - r_peak) : (r_peak - r_sus);
        end
        if (r_state == ST_LOAD) begin
            r_base <= ld_base;
            r_sub  <= ld_sub;
            r_den  <= ld_den;
            r_gain <= ld_gain;
        end
        if ((r_state == ST_DIV) && div_done) begin
            r_gain <= ramp_gain;
        end
        if (r_state == ST_SCALE) begin
            r_mag <= scaled[SCALE_W-1:SCALE_W-SAMPLE_W];
        end
        if (emit_go) begin
            r_out.out_sample <= r_wave[SAMPLE_W-1] ? -$signed(r_mag) : $signed(r_mag);
            r_out.note_last  <= r_last;
        end
    end

    adsr_serial_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mul_mcand),
        .i_mplier (mul_mplier),
        .o_done   (mul_done),
        .o_prod   (mul_prod)
    );

    adsr_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mul_prod),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    a_mul_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == ST_MUL))
        else $error("multiplier finished outside its state");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside its state");

    a_index_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_last || (r_index == COUNT_BITS'(r_cur + 1'b1))))
        else $error("sample index did not advance or wrap");

    a_mag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_mag <= OUT_SCALE))
        else $error("scaled magnitude above full scale");
endmodule

FILE: verif/adsr_envelope_shaper_test.sv
`timescale 1ns / 1ps
// Self-checking bench for adsr_envelope_shaper: a predictor of the envelope gain, saturation
// and scaling checks every result, with random idling on both stream channels.
// Depends on adsr_pkg, adsr_stream_if and adsr_envelope_shaper from the hdl folder.
module adsr_envelope_shaper_test;
    import adsr_pkg::*;

    localparam int COUNT_BITS    = 24;
    localparam int ITEM_TARGET   = 1550;
    localparam int SETTLE_CYCLES = 80;
    localparam int DRAIN_CYCLES  = 100;
    localparam int CYCLE_LIMIT   = 1_000_000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    t_cfg_idx             cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    adsr_stream_if #(.T(t_in_item))  in_ch ();
    adsr_stream_if #(.T(t_out_item)) out_ch ();

    adsr_envelope_shaper #(.COUNT_BITS(COUNT_BITS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Register shadows and note position of the predictor
    logic [CFG_W-1:0]      reg_note_len = NOTE_LENGTH_RST;
    logic [CFG_W-1:0]      reg_attack   = ATTACK_RST;
    logic [CFG_W-1:0]      reg_decay    = DECAY_RST;
    logic [CFG_W-1:0]      reg_release  = RELEASE_RST;
    logic [LEVEL_W-1:0]    reg_peak     = PEAK_RST;
    logic [LEVEL_W-1:0]    reg_sustain  = SUSTAIN_RST;
    logic [COUNT_BITS-1:0] note_pos     = '0;

    t_in_item  wave_q[$];
    t_out_item shaped_due[$];

    bit calm;
    bit in_taken;
    int queued;
    int accepted;
    int results;
    int mismatches;
    int settings;
    int note_ends;
    int attack_hits, decay_hits, sustain_hits, release_hits;
    int cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned envelope_gain(longint unsigned pos);
        longint unsigned a, d, r, p, s, t, drop;
        longint          sus_end;
        a = reg_attack;
        d = reg_decay;
        r = reg_release;
        p = reg_peak;
        s = reg_sustain;
        sus_end = longint'(reg_note_len) - longint'(reg_release);
        if (pos < a) begin
            attack_hits++;
            return pos * p / a;
        end
        if (pos < a + d) begin
            decay_hits++;
            t = pos - a;
            if (p >= s)
                return p - t * (p - s) / d;
            return p + t * (s - p) / d;
        end
        if (longint'(pos) < sus_end) begin
            sustain_hits++;
            return s;
        end
        release_hits++;
        if (r == 0)
            return 0;
        t = longint'(pos) - sus_end;
        drop = t * s / r;
        return (drop >= s) ? 0 : s - drop;
    endfunction

    function automatic t_out_item shape_sample(logic signed [SAMPLE_W-1:0] wave);
        t_out_item       res;
        longint unsigned pos, gain;
        longint          prod, mag, shaped;
        pos = note_pos;
        gain = envelope_gain(pos);
        prod = longint'(wave) * longint'(gain);
        if (prod > longint'(UNITY_Q29))
            prod = longint'(UNITY_Q29);
        if (prod < -longint'(UNITY_Q29))
            prod = -longint'(UNITY_Q29);
        mag = (prod < 0) ? -prod : prod;
        shaped = mag * longint'(OUT_SCALE) / longint'(UNITY_Q29);
        if (prod < 0)
            shaped = -shaped;
        res.out_sample = shaped[SAMPLE_W-1:0];
        res.note_last = (pos + 1 >= reg_note_len);
        if (res.note_last) begin
            note_ends++;
            note_pos = '0;
        end else begin
            note_pos = COUNT_BITS'(pos + 1);
        end
        return res;
    endfunction

    task automatic note_error(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", what);
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        results++;
        if (shaped_due.size() == 0) begin
            note_error($sformatf("result sample %0d last %0b with no request pending",
                                 got.out_sample, got.note_last));
        end else begin
            want = shaped_due.pop_front();
            if (got.out_sample !== want.out_sample)
                note_error($sformatf("result %0d: out_sample expected %0d, got %0d",
                                     results, want.out_sample, got.out_sample));
            if (got.note_last !== want.note_last)
                note_error($sformatf("result %0d: note_last expected %0b, got %0b",
                                     results, want.note_last, got.note_last));
        end
    endtask

    // Sender: hold a request until taken, otherwise idle or pull the next sample
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (wave_q.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= wave_q.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= calm || ($urandom_range(0, 99) >= 31);
    end

    // Monitor: check results before predicting the request taken at the same edge
    always @(posedge i_clk) begin
        in_taken <= in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                check_result(out_ch.data);
            if (in_ch.valid && in_ch.ready) begin
                accepted++;
                shaped_due.push_back(shape_sample(in_ch.data.wave_sample));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d requests waiting, %0d results outstanding",
                     cycles, wave_q.size(), shaped_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic queue_wave(input logic [SAMPLE_W-1:0] w);
        t_in_item it;
        it.wave_sample = w;
        wave_q.push_back(it);
        queued++;
    endtask

    task automatic wait_idle();
        while (wave_q.size() != 0 || in_ch.valid || shaped_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            CFG_NOTE_LENGTH: reg_note_len = value;
            CFG_ATTACK:      reg_attack   = value;
            CFG_DECAY:       reg_decay    = value;
            CFG_RELEASE:     reg_release  = value;
            CFG_PEAK:        reg_peak     = value[LEVEL_W-1:0];
            CFG_SUSTAIN:     reg_sustain  = value[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [CFG_W-1:0] n_len, att_len, dec_len, rel_len,
                                 input logic [LEVEL_W-1:0] peak_lvl, sus_lvl);
        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        calm = 1'b0;
        write_reg(CFG_NOTE_LENGTH, n_len);
        write_reg(CFG_ATTACK, att_len);
        write_reg(CFG_DECAY, dec_len);
        write_reg(CFG_RELEASE, rel_len);
        write_reg(CFG_PEAK, CFG_W'(peak_lvl));
        write_reg(CFG_SUSTAIN, CFG_W'(sus_lvl));
        @(negedge i_clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [CFG_W-1:0] pick_span();
        return ($urandom_range(0, 5) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 40));
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            default: return LEVEL_W'($urandom);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_wave();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic random_setting();
        case ($urandom_range(0, 9))
            0: apply_setting('1, '1, '1, '1, '1, '1);
            1: apply_setting('1, '0, '0, '0, '1, '1);
            2: apply_setting(CFG_W'($urandom_range(0, 4)), '0, '0, '0,
                             pick_level(), pick_level());
            default: apply_setting(CFG_W'($urandom_range(1, 96)), pick_span(), pick_span(),
                                   pick_span(), pick_level(), pick_level());
        endcase
    endtask

    initial begin
        int n;
        bit calm_done;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_NOTE_LENGTH;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        calm_done    = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: sample extremes at the foot of the attack ramp
        queue_wave(16'h8000);
        queue_wave(16'h7FFF);
        queue_wave(16'h0000);
        queue_wave(16'h0001);
        queue_wave(16'hFFFF);

        // Short note through every region, peak gain high enough to saturate
        apply_setting(24'd12, 24'd3, 24'd3, 24'd3, 16'hFFFF, 16'd40000);
        for (int k = 0; k < 12; k++)
            queue_wave(k[0] ? 16'h7FFF : 16'h8000);

        // Shorten the note below the running index, rising decay, no release ramp
        apply_setting(24'd2, 24'd0, 24'd1, 24'd0, 16'd1000, 16'd60000);
        repeat (3) queue_wave(16'h7FFF);

        // Empty note with a release ramp longer than the note
        apply_setting(24'd0, 24'd0, 24'd5, 24'd100, 16'd20000, 16'd9000);
        queue_wave(16'h4000);
        queue_wave(16'hC000);

        while (queued < ITEM_TARGET) begin
            random_setting();
            if (!calm_done && settings > 6) begin
                calm = 1'b1;
                calm_done = 1'b1;
                n = 150;
            end else begin
                n = $urandom_range(20, 70);
            end
            repeat (n) queue_wave(pick_wave());
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d requests over %0d register settings, %0d note ends",
                 accepted, settings, note_ends);
        $display("gain regions hit: attack %0d, decay %0d, sustain %0d, release %0d; %0d errors",
                 attack_hits, decay_hits, sustain_hits, release_hits, mismatches);
        if (mismatches == 0 && shaped_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
hdl/adsr_pkg.sv
hdl/adsr_stream_if.sv
hdl/adsr_serial_mul.sv
hdl/adsr_serial_div.sv
hdl/adsr_envelope_shaper.sv
verif/adsr_envelope_shaper_test.sv
